FILE: rtl/omp_pkg.sv
// ----------------------------------------------------------------------------
// omp_pkg
// Types and constants shared by the oscillating motor position controller,
// its channel interfaces and its checker.
// ----------------------------------------------------------------------------
package omp_pkg;

    localparam int unsigned POS_W   = 7;
    localparam int unsigned DRIVE_W = 2;
    localparam int unsigned PHASE_W = 3;
    localparam int unsigned CFG_W   = 7;
    localparam int unsigned CFG_IDX_W = 1;

    localparam logic [CFG_IDX_W-1:0] CFG_WRAP_LIMIT = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_CW_TARGET  = 1'b1;

    localparam logic [POS_W-1:0] WRAP_LIMIT_RST = 7'd99;
    localparam logic [POS_W-1:0] CW_TARGET_RST  = 7'd0;

    localparam logic [DRIVE_W-1:0] DRV_NONE    = 2'd0;
    localparam logic [DRIVE_W-1:0] DRV_BRAKE   = 2'd1;
    localparam logic [DRIVE_W-1:0] DRV_REVERSE = 2'd2;
    localparam logic [DRIVE_W-1:0] DRV_FORWARD = 2'd3;

    localparam logic [PHASE_W-1:0] PH_CW     = 3'd0;
    localparam logic [PHASE_W-1:0] PH_CW_B1  = 3'd1;
    localparam logic [PHASE_W-1:0] PH_CW_B2  = 3'd2;
    localparam logic [PHASE_W-1:0] PH_ACW    = 3'd3;
    localparam logic [PHASE_W-1:0] PH_ACW_B1 = 3'd4;
    localparam logic [PHASE_W-1:0] PH_ACW_B2 = 3'd5;

    typedef enum logic [5:0] {
        S_CW     = 6'b000001,
        S_CW_B1  = 6'b000010,
        S_CW_B2  = 6'b000100,
        S_ACW    = 6'b001000,
        S_ACW_B1 = 6'b010000,
        S_ACW_B2 = 6'b100000
    } t_state;

    typedef struct packed {
        logic phase_b_level;
    } t_in_item;

    typedef struct packed {
        logic [DRIVE_W-1:0] drive_cmd;
        logic               edge_rising;
        logic [POS_W-1:0]   position;
        logic [PHASE_W-1:0] phase;
    } t_out_item;

endpackage

FILE: rtl/omp_in_if.sv
// ----------------------------------------------------------------------------
// omp_in_if
// Valid/ready channel carrying one encoder capture edge.
// ----------------------------------------------------------------------------
interface omp_in_if;
    import omp_pkg::*;

    logic     valid;
    logic     ready;
    t_in_item data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);

endinterface

FILE: rtl/omp_out_if.sv
// ----------------------------------------------------------------------------
// omp_out_if
// Valid/ready channel carrying one drive/position result.
// ----------------------------------------------------------------------------
interface omp_out_if;
    import omp_pkg::*;

    logic      valid;
    logic      ready;
    t_out_item data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);

endinterface

FILE: rtl/oscillating_motor_position_fsm_top.sv
// ----------------------------------------------------------------------------
// oscillating_motor_position_fsm_top
// Encoder-edge driven oscillation controller: six-phase direction machine,
// wrapping position count and capture polarity, one result per edge.
//
//   channel   dir   payload                                   handshake
//   i_in      in    phase_b_level                             valid/ready
//   o_out     out   drive_cmd, edge_rising, position, phase   valid/ready
//   cfg       in    i_cfg_idx, i_cfg_data                     i_cfg_we
//
// one edge per cycle while the output register is empty or being taken; the
// result is registered and shows in the cycle after the transfer
// the input stays ready while the output register is empty or being taken
// synchronous active-low reset: phase clockwise, position 0, rising edges
// ----------------------------------------------------------------------------
module oscillating_motor_position_fsm_top (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    omp_in_if.sink                         i_in,
    omp_out_if.source                      o_out,
    input  logic                           i_cfg_we,
    input  logic [omp_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [omp_pkg::CFG_W-1:0]      i_cfg_data
);
    import omp_pkg::*;

    logic [POS_W-1:0] r_wrap_limit;
    logic [POS_W-1:0] r_cw_target;

    t_state           r_state, n_state;
    logic [POS_W-1:0] r_pos, n_pos;
    logic             r_pol, n_pol;
    logic [DRIVE_W-1:0] n_drive;

    logic      r_out_valid;
    t_out_item r_out;

    logic in_xfer;
    logic high;
    logic [POS_W-1:0] pos_up;
    logic [POS_W-1:0] pos_dn;
    logic [PHASE_W-1:0] n_phase;

    assign i_in.ready = !r_out_valid || o_out.ready;
    assign in_xfer    = i_in.valid && i_in.ready;
    assign high       = i_in.data.phase_b_level;

    assign pos_up = (r_pos >= r_wrap_limit) ? '0 : r_pos + 1'b1;
    assign pos_dn = (r_pos == '0) ? r_wrap_limit : r_pos - 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wrap_limit <= WRAP_LIMIT_RST;
            r_cw_target  <= CW_TARGET_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_WRAP_LIMIT: r_wrap_limit <= i_cfg_data;
                CFG_CW_TARGET:  r_cw_target  <= i_cfg_data;
                default: ;
            endcase
        end
    end

    always_comb begin
        n_state = r_state;
        n_pos   = r_pos;
        n_pol   = r_pol;
        n_drive = DRV_NONE;
        unique case (r_state)
            S_CW: begin
                if (high) begin
                    n_pos = pos_up;
                    if (pos_up == r_cw_target) begin
                        n_state = S_CW_B1;
                        n_drive = DRV_BRAKE;
                        n_pol   = 1'b0;
                    end
                end
            end
            S_CW_B1: begin
                n_drive = DRV_REVERSE;
                if (high) begin
                    n_state = S_ACW;
                end else begin
                    n_pol   = 1'b1;
                    n_state = S_CW_B2;
                end
            end
            S_CW_B2: begin
                n_drive = DRV_REVERSE;
                n_pos   = pos_up;
                n_state = high ? S_CW_B1 : S_ACW;
                n_pol   = 1'b0;
            end
            S_ACW: begin
                if (high) begin
                    n_pos = pos_dn;
                    if (pos_dn == '0) begin
                        n_state = S_ACW_B1;
                        n_drive = DRV_BRAKE;
                        n_pol   = 1'b1;
                    end
                end
            end
            S_ACW_B1: begin
                n_drive = DRV_FORWARD;
                if (high) begin
                    n_state = S_CW;
                end else begin
                    n_state = S_ACW_B2;
                    n_pol   = 1'b0;
                end
            end
            S_ACW_B2: begin
                n_drive = DRV_FORWARD;
                n_pos   = pos_dn;
                n_state = high ? S_ACW_B1 : S_CW;
                n_pol   = 1'b1;
            end
            default: ;
        endcase
    end

    always_comb begin
        unique case (n_state)
            S_CW:     n_phase = PH_CW;
            S_CW_B1:  n_phase = PH_CW_B1;
            S_CW_B2:  n_phase = PH_CW_B2;
            S_ACW:    n_phase = PH_ACW;
            S_ACW_B1: n_phase = PH_ACW_B1;
            S_ACW_B2: n_phase = PH_ACW_B2;
            default:  n_phase = PH_CW;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CW;
            r_pos   <= '0;
            r_pol   <= 1'b1;
        end else if (in_xfer) begin
            r_state <= n_state;
            r_pos   <= n_pos;
            r_pol   <= n_pol;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (in_xfer) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_xfer) begin
            r_out.drive_cmd   <= n_drive;
            r_out.edge_rising <= n_pol;
            r_out.position    <= n_pos;
            r_out.phase       <= n_phase;
        end
    end

    assign o_out.valid = r_out_valid;
    assign o_out.data  = r_out;

endmodule

FILE: rtl/omp_checker.sv
// ----------------------------------------------------------------------------
// omp_checker
// Port-level checks on the oscillation controller, bound to the top level.
// ----------------------------------------------------------------------------
module omp_checker (
    input logic                          i_clk,
    input logic                          i_rst_n,
    input logic                          i_in_valid,
    input logic                          i_in_ready,
    input logic                          i_out_valid,
    input logic                          i_out_ready,
    input logic [omp_pkg::DRIVE_W-1:0]   i_drive_cmd,
    input logic                          i_edge_rising,
    input logic [omp_pkg::POS_W-1:0]     i_position,
    input logic [omp_pkg::PHASE_W-1:0]   i_phase
);
    import omp_pkg::*;

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_drive_cmd)
            && $stable(i_edge_rising) && $stable(i_position) && $stable(i_phase))
        else $error("stalled result changed");

    a_result_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && i_in_ready |=> i_out_valid)
        else $error("transfer without result");

    a_brake_phase: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_drive_cmd == DRV_BRAKE |->
            (i_phase == PH_CW_B1 && !i_edge_rising)
            || (i_phase == PH_ACW_B1 && i_edge_rising))
        else $error("brake outside a turning point");

    a_reverse_phase: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_drive_cmd == DRV_REVERSE |->
            i_phase == PH_CW_B1 || i_phase == PH_CW_B2 || i_phase == PH_ACW)
        else $error("reverse drive in wrong phase");

    a_forward_phase: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_drive_cmd == DRV_FORWARD |->
            i_phase == PH_ACW_B1 || i_phase == PH_ACW_B2 || i_phase == PH_CW)
        else $error("forward drive in wrong phase");

endmodule

bind oscillating_motor_position_fsm_top omp_checker u_omp_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .i_in_valid    (i_in.valid),
    .i_in_ready    (i_in.ready),
    .i_out_valid   (o_out.valid),
    .i_out_ready   (o_out.ready),
    .i_drive_cmd   (o_out.data.drive_cmd),
    .i_edge_rising (o_out.data.edge_rising),
    .i_position    (o_out.data.position),
    .i_phase       (o_out.data.phase)
);

FILE: tb/testbench.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Checks the oscillating motor position controller edge by edge. A queue of
// encoder edges feeds a valid/ready driver; every accepted edge is run through
// a local copy of the six-phase direction machine, position count and capture
// polarity, and each result the block returns is compared with the oldest
// prediction. Wrap limit and clockwise target are changed between phases,
// including a limit below the current count and a zero limit.
// ----------------------------------------------------------------------------
module testbench;
    import omp_pkg::*;

    localparam int HOLD_LEN   = 80;
    localparam int STALL_MAX  = 3000;

    logic clk;
    logic rst_n;
    logic cfg_we;
    logic [CFG_IDX_W-1:0] cfg_idx;
    logic [CFG_W-1:0]     cfg_data;

    omp_in_if  in_ch ();
    omp_out_if out_ch ();

    oscillating_motor_position_fsm_top u_top (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .i_in       (in_ch),
        .o_out      (out_ch),
        .i_cfg_we   (cfg_we),
        .i_cfg_idx  (cfg_idx),
        .i_cfg_data (cfg_data)
    );

    // local copy of the controller
    logic [POS_W-1:0]   wrap_limit_c = WRAP_LIMIT_RST;
    logic [POS_W-1:0]   cw_target_c  = CW_TARGET_RST;
    logic [PHASE_W-1:0] cur_phase    = PH_CW;
    logic [POS_W-1:0]   cur_pos      = '0;
    logic               cur_rising   = 1'b1;

    bit        pending_edges[$];
    t_out_item expected_results[$];

    int edges_queued    = 0;
    int edges_taken     = 0;
    int results_checked = 0;
    int mismatches      = 0;
    int settings_done   = 0;
    int stall_cycles    = 0;
    int tx_idle_pct     = 26;
    int rx_idle_pct     = 79;
    bit hold_req        = 1'b0;
    int hold_count      = 0;
    bit in_taken        = 1'b0;

    always #10 clk = ~clk;

    function automatic logic [POS_W-1:0] step_up(input logic [POS_W-1:0] p);
        return (p >= wrap_limit_c) ? '0 : p + 1'b1;
    endfunction

    function automatic logic [POS_W-1:0] step_down(input logic [POS_W-1:0] p);
        return (p == '0) ? wrap_limit_c : p - 1'b1;
    endfunction

    function automatic t_out_item predict_edge(input logic level);
        t_out_item r;
        logic [DRIVE_W-1:0] drv;
        drv = DRV_NONE;
        case (cur_phase)
            PH_CW: begin
                if (level) begin
                    cur_pos = step_up(cur_pos);
                    if (cur_pos == cw_target_c) begin
                        cur_phase  = PH_CW_B1;
                        drv        = DRV_BRAKE;
                        cur_rising = 1'b0;
                    end
                end
            end
            PH_CW_B1: begin
                drv = DRV_REVERSE;
                if (level) begin
                    cur_phase = PH_ACW;
                end else begin
                    cur_rising = 1'b1;
                    cur_phase  = PH_CW_B2;
                end
            end
            PH_CW_B2: begin
                drv        = DRV_REVERSE;
                cur_pos    = step_up(cur_pos);
                cur_phase  = level ? PH_CW_B1 : PH_ACW;
                cur_rising = 1'b0;
            end
            PH_ACW: begin
                if (level) begin
                    cur_pos = step_down(cur_pos);
                    if (cur_pos == '0) begin
                        cur_phase  = PH_ACW_B1;
                        drv        = DRV_BRAKE;
                        cur_rising = 1'b1;
                    end
                end
            end
            PH_ACW_B1: begin
                drv = DRV_FORWARD;
                if (level) begin
                    cur_phase = PH_CW;
                end else begin
                    cur_phase  = PH_ACW_B2;
                    cur_rising = 1'b0;
                end
            end
            PH_ACW_B2: begin
                drv        = DRV_FORWARD;
                cur_pos    = step_down(cur_pos);
                cur_phase  = level ? PH_ACW_B1 : PH_CW;
                cur_rising = 1'b1;
            end
            default: ;
        endcase
        r.drive_cmd   = drv;
        r.edge_rising = cur_rising;
        r.position    = cur_pos;
        r.phase       = cur_phase;
        return r;
    endfunction

    // edge driver
    always @(negedge clk) begin
        if (!rst_n) begin
            in_ch.valid <= 1'b0;
        end else if (!in_ch.valid || in_taken) begin
            if (pending_edges.size() != 0 && $urandom_range(99) >= tx_idle_pct) begin
                in_ch.valid              <= 1'b1;
                in_ch.data.phase_b_level <= pending_edges.pop_front();
            end else begin
                in_ch.valid <= 1'b0;
            end
        end
    end

    // result receiver, with a one-shot long hold-off
    always @(negedge clk) begin
        if (hold_req && hold_count < HOLD_LEN) begin
            out_ch.ready <= 1'b0;
            hold_count   <= hold_count + 1;
        end else begin
            out_ch.ready <= ($urandom_range(99) >= rx_idle_pct);
        end
    end

    // transfer monitor and checker
    always @(posedge clk) begin : monitor
        bit        in_fire;
        bit        out_fire;
        t_out_item want;
        t_out_item got;
        in_fire  = rst_n && in_ch.valid && in_ch.ready;
        out_fire = rst_n && out_ch.valid && out_ch.ready;
        in_taken <= in_fire;
        if (in_fire) begin
            expected_results.push_back(predict_edge(in_ch.data.phase_b_level));
            edges_taken++;
        end
        if (out_fire) begin
            got = out_ch.data;
            if (expected_results.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result: drive %0d rising %0b pos %0d phase %0d",
                             got.drive_cmd, got.edge_rising, got.position, got.phase);
            end else begin
                want = expected_results.pop_front();
                if (got.drive_cmd !== want.drive_cmd || got.edge_rising !== want.edge_rising
                    || got.position !== want.position || got.phase !== want.phase) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display({"result %0d: expected drive %0d rising %0b pos %0d ",
                                  "phase %0d, got drive %0d rising %0b pos %0d phase %0d"},
                                 results_checked, want.drive_cmd, want.edge_rising,
                                 want.position, want.phase, got.drive_cmd,
                                 got.edge_rising, got.position, got.phase);
                end
            end
            results_checked++;
        end
        if (in_fire || out_fire) begin
            stall_cycles = 0;
        end else begin
            stall_cycles++;
            if (stall_cycles >= STALL_MAX) begin
                $display("no transfer for %0d cycles", STALL_MAX);
                $display("end of test: mismatches");
                $finish;
            end
        end
    end

    task automatic push_edge(input bit level);
        pending_edges.push_back(level);
        edges_queued++;
    endtask

    task automatic push_random_edges(input int n, input int high_pct);
        repeat (n) push_edge($urandom_range(99) < high_pct);
    endtask

    task automatic wait_drained();
        while (edges_taken != edges_queued || expected_results.size() != 0)
            @(negedge clk);
        repeat (3) @(negedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
        cfg_idx  <= idx;
        cfg_data <= val;
        cfg_we   <= 1'b1;
        @(negedge clk);
        cfg_we   <= 1'b0;
        @(negedge clk);
    endtask

    task automatic apply_setting(input logic [POS_W-1:0] wrap, input logic [POS_W-1:0] target);
        wait_drained();
        write_reg(CFG_WRAP_LIMIT, wrap);
        write_reg(CFG_CW_TARGET, target);
        wrap_limit_c = wrap;
        cw_target_c  = target;
        settings_done++;
    endtask

    initial begin : stimulus
        bit directed_seq[$];
        logic [POS_W-1:0] wrap;
        logic [POS_W-1:0] target;
        clk       = 1'b0;
        rst_n     = 1'b0;
        cfg_we    = 1'b0;
        cfg_idx   = '0;
        cfg_data  = '0;
        repeat (3) @(negedge clk);
        rst_n <= 1'b1;

        // reset values: a few edges of both levels
        directed_seq = '{1'b1, 1'b0, 1'b1, 1'b1, 1'b0, 1'b1};
        foreach (directed_seq[i]) push_edge(directed_seq[i]);

        // small range, count starts above the limit; walks every phase transition
        apply_setting(7'd3, 7'd2);
        directed_seq = '{1'b1, 1'b1, 1'b1, 1'b0, 1'b1, 1'b1, 1'b0, 1'b1,
                         1'b1, 1'b1, 1'b0, 1'b1, 1'b0, 1'b0, 1'b1, 1'b1,
                         1'b1, 1'b1, 1'b0, 1'b0, 1'b1, 1'b1, 1'b1, 1'b1};
        foreach (directed_seq[i]) push_edge(directed_seq[i]);

        // limit and clockwise target of one
        apply_setting(7'd1, 7'd1);
        push_random_edges(150, 70);

        // zero limit
        apply_setting(7'd0, 7'd0);
        push_random_edges(60, 65);

        tx_idle_pct = 79;
        rx_idle_pct = 26;
        apply_setting(7'd127, 7'd127);
        push_random_edges(200, 90);
        apply_setting(7'd127, 7'd0);
        push_random_edges(100, 75);

        for (int chunk = 0; chunk < 8; chunk++) begin
            wrap   = ($urandom_range(3) == 0) ? POS_W'($urandom_range(127, 1))
                                              : POS_W'($urandom_range(12, 1));
            target = ($urandom_range(7) == 0) ? POS_W'($urandom_range(127))
                                              : POS_W'($urandom_range(wrap));
            apply_setting(wrap, target);
            if (chunk == 2) begin
                tx_idle_pct = 0;
                rx_idle_pct = 0;
                hold_req    = 1'b1;
            end
            push_random_edges(100, int'($urandom_range(85, 55)));
        end

        wait_drained();
        $display("%0d edges accepted, %0d results checked over %0d register settings",
                 edges_taken, results_checked, settings_done);
        $display("covered all six phases, wrap below count, zero limit, long output stall");
        if (mismatches == 0) begin
            $display("end of test: clean");
        end else begin
            $display("%0d mismatches", mismatches);
            $display("end of test: mismatches");
        end
        $finish;
    end

endmodule
